// ===== hw/rtl/mbra_pkg.sv =====
// shared types and constants for the maximal black rectangle block
package mbra_pkg;
  localparam int PIXEL_W = 1;
  localparam int WIDTH_W = 11;
  localparam int AREA_W  = 21;
  localparam logic [AREA_W-1:0] AREA_LIMIT = {AREA_W{1'b1}};

  typedef struct packed {
    logic pixel;
    logic last_pixel;
    logic row_end;
  } cmd_t;
endpackage

// ===== hw/rtl/mbra_front.sv =====
// front part: column tracking and row-end classification of each pixel item
module mbra_front #(
  parameter int MAX_COLS = 1024,
  parameter int COL_W = 10
) (
  input  logic clk,
  input  logic rst,
  input  logic [10:0] row_width,
  input  logic push,
  input  logic pixel,
  input  logic last_pixel,
  input  logic q_full,
  output logic full,
  output logic q_push,
  output mbra_pkg::cmd_t q_cmd
);
  import mbra_pkg::*;

  logic [COL_W-1:0] column_position;
  logic [COL_W-1:0] column_position_next;
  logic [COL_W:0] width_eff;
  logic row_end;

  always_comb begin
    if (row_width == '0) begin
      width_eff = (COL_W+1)'(1);
    end else if (32'(row_width) > 32'(MAX_COLS)) begin
      width_eff = (COL_W+1)'(MAX_COLS);
    end else begin
      width_eff = (COL_W+1)'(row_width);
    end
  end

  assign row_end = ((COL_W+1)'(column_position) + (COL_W+1)'(1) >= width_eff) ||
                   last_pixel;
  assign full = q_full;
  assign q_push = push && !q_full;
  assign q_cmd = '{pixel: pixel, last_pixel: last_pixel, row_end: row_end};
  assign column_position_next = row_end ? '0 : column_position + COL_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
    end else if (q_push) begin
      column_position <= column_position_next;
    end
  end
endmodule

// ===== hw/rtl/mbra_queue.sv =====
// small command queue between front and back parts
module mbra_queue #(
  parameter int DEPTH_W = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  mbra_pkg::cmd_t wdata,
  output logic full,
  input  logic pop,
  output mbra_pkg::cmd_t rdata,
  output logic empty
);
  import mbra_pkg::*;

  localparam int DEPTH = 1 << DEPTH_W;
  cmd_t mem [DEPTH];
  logic [DEPTH_W-1:0] wr_ptr;
  logic [DEPTH_W-1:0] rd_ptr;
  logic [DEPTH_W:0] count;

  assign full = (count == (DEPTH_W+1)'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + DEPTH_W'(1);
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + DEPTH_W'(1);
      end
      count <= count + (DEPTH_W+1)'(push && !full) - (DEPTH_W+1)'(pop && !empty);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |=> count <= (DEPTH_W+1)'(DEPTH)) else $error("queue overflow");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !full && !(pop && !empty)) |=> count == $past(count) + (DEPTH_W+1)'(1))
    else $error("queue count");
  a_empty_ptr: assert property (@(posedge clk) disable iff (rst)
    empty |-> wr_ptr == rd_ptr) else $error("queue pointers");
endmodule

// ===== hw/rtl/mbra_back.sv =====
// back part: height update, two stack passes per row, running maximum
module mbra_back #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024,
  parameter int COL_W = 10,
  parameter int HGT_W = 11
) (
  input  logic clk,
  input  logic rst,
  input  logic q_empty,
  input  mbra_pkg::cmd_t q_cmd,
  output logic q_pop,
  output logic empty,
  input  logic pop,
  output logic [20:0] best_area
);
  import mbra_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_HWR  = 4'd1;
  localparam logic [3:0] S_FRD  = 4'd2;
  localparam logic [3:0] S_FCMP = 4'd3;
  localparam logic [3:0] S_FPOP = 4'd4;
  localparam logic [3:0] S_BRD  = 4'd5;
  localparam logic [3:0] S_BCMP = 4'd6;
  localparam logic [3:0] S_BPOP = 4'd7;
  localparam logic [3:0] S_MUL  = 4'd8;
  localparam logic [3:0] S_ACC  = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;
  localparam logic [3:0] S_CLR  = 4'd11;
  localparam int PRD_W = HGT_W + COL_W + 1;
  localparam int CMP_W = (PRD_W > AREA_W) ? PRD_W : AREA_W;
  localparam int STK_W = COL_W + HGT_W;

  logic [3:0] state;
  logic [HGT_W-1:0] heights [MAX_COLS];
  logic [STK_W-1:0] stack_mem [MAX_COLS];
  logic [COL_W:0] lefts [MAX_COLS];

  logic [COL_W-1:0] column_position;
  logic [COL_W:0] cols;
  logic [COL_W-1:0] idx;
  logic [COL_W:0] stack_depth;
  logic [COL_W-1:0] top_idx;
  logic [HGT_W-1:0] top_h;
  logic [HGT_W-1:0] h_rd;
  logic [STK_W-1:0] s_rd;
  logic [COL_W:0] l_rd;
  logic [COL_W:0] span;
  logic [PRD_W-1:0] prod;
  logic [AREA_W-1:0] running_best;
  logic [AREA_W-1:0] result;
  logic pixel_q, last_q, row_end_q;
  logic out_valid;
  logic [COL_W-1:0] clr_idx;

  logic [COL_W-1:0] h_addr;
  logic h_we;
  logic [HGT_W-1:0] h_wdata;
  logic pop_top;
  logic s_we;
  logic [COL_W-1:0] s_waddr;
  logic [COL_W-1:0] s_raddr;
  logic [STK_W-1:0] s_wdata;
  logic l_we;
  logic [COL_W:0] l_wdata;
  logic [AREA_W-1:0] area_sat;

  assign empty = !out_valid;
  assign best_area = result;
  assign q_pop = (state == S_IDLE) && !q_empty && (!q_cmd.last_pixel || !out_valid);

  assign pop_top = (stack_depth != '0) && (top_h >= h_rd);
  assign s_we = ((state == S_FCMP) || (state == S_BCMP)) && !pop_top;
  assign s_waddr = stack_depth[COL_W-1:0];
  assign s_raddr = COL_W'(stack_depth - (COL_W+1)'(2));
  assign s_wdata = {idx, h_rd};
  assign l_we = (state == S_FCMP) && !pop_top;
  assign l_wdata = (stack_depth != '0) ? (COL_W+1)'(top_idx) + (COL_W+1)'(1) : '0;
  assign area_sat = (CMP_W'(prod) > CMP_W'(AREA_LIMIT)) ? AREA_LIMIT : AREA_W'(prod);

  always_comb begin
    h_we = 1'b0;
    h_wdata = '0;
    h_addr = column_position;
    unique case (state)
      S_HWR: begin
        h_we = 1'b1;
        if (!pixel_q) begin
          h_wdata = '0;
        end else if ({1'b0, h_rd} < (HGT_W+1)'(MAX_ROWS)) begin
          h_wdata = h_rd + HGT_W'(1);
        end else begin
          h_wdata = HGT_W'(MAX_ROWS);
        end
      end
      S_CLR: begin
        h_we = 1'b1;
        h_addr = clr_idx;
      end
      S_FRD, S_FCMP, S_FPOP, S_BRD, S_BCMP, S_BPOP, S_MUL, S_ACC: h_addr = idx;
      default: h_addr = column_position;
    endcase
  end

  always_ff @(posedge clk) begin
    if (h_we) begin
      heights[h_addr] <= h_wdata;
    end
    h_rd <= heights[h_addr];
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      stack_mem[s_waddr] <= s_wdata;
    end
    s_rd <= stack_mem[s_raddr];
  end

  always_ff @(posedge clk) begin
    if (l_we) begin
      lefts[idx] <= l_wdata;
    end
    l_rd <= lefts[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      column_position <= '0;
      running_best <= '0;
      out_valid <= 1'b0;
      stack_depth <= '0;
      clr_idx <= '0;
    end else begin
      if (out_valid && pop) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            pixel_q <= q_cmd.pixel;
            last_q <= q_cmd.last_pixel;
            row_end_q <= q_cmd.row_end;
            state <= S_HWR;
          end
        end
        S_HWR: begin
          if (row_end_q) begin
            cols <= (COL_W+1)'(column_position) + (COL_W+1)'(1);
            idx <= '0;
            stack_depth <= '0;
            state <= S_FRD;
          end else begin
            column_position <= column_position + COL_W'(1);
            state <= S_IDLE;
          end
        end
        S_FRD: state <= S_FCMP;
        S_FCMP: begin
          if (pop_top) begin
            stack_depth <= stack_depth - (COL_W+1)'(1);
            state <= S_FPOP;
          end else begin
            top_idx <= idx;
            top_h <= h_rd;
            if ((COL_W+1)'(idx) + (COL_W+1)'(1) == cols) begin
              stack_depth <= '0;
              idx <= COL_W'(cols - (COL_W+1)'(1));
              state <= S_BRD;
            end else begin
              stack_depth <= stack_depth + (COL_W+1)'(1);
              idx <= idx + COL_W'(1);
              state <= S_FRD;
            end
          end
        end
        S_FPOP: begin
          if (stack_depth != '0) begin
            {top_idx, top_h} <= s_rd;
          end
          state <= S_FCMP;
        end
        S_BRD: state <= S_BCMP;
        S_BCMP: begin
          if (pop_top) begin
            stack_depth <= stack_depth - (COL_W+1)'(1);
            state <= S_BPOP;
          end else begin
            span <= ((stack_depth != '0) ? (COL_W+1)'(top_idx) : cols) - l_rd;
            top_idx <= idx;
            top_h <= h_rd;
            stack_depth <= stack_depth + (COL_W+1)'(1);
            state <= S_MUL;
          end
        end
        S_BPOP: begin
          if (stack_depth != '0) begin
            {top_idx, top_h} <= s_rd;
          end
          state <= S_BCMP;
        end
        S_MUL: begin
          prod <= PRD_W'(h_rd) * PRD_W'(span);
          state <= S_ACC;
        end
        S_ACC: begin
          if (area_sat > running_best) begin
            running_best <= area_sat;
          end
          if (idx == '0) begin
            state <= S_DONE;
          end else begin
            idx <= idx - COL_W'(1);
            state <= S_BRD;
          end
        end
        S_DONE: begin
          stack_depth <= '0;
          column_position <= '0;
          if (last_q) begin
            result <= running_best;
            out_valid <= 1'b1;
            running_best <= '0;
            clr_idx <= '0;
            state <= S_CLR;
          end else begin
            state <= S_IDLE;
          end
        end
        S_CLR: begin
          clr_idx <= clr_idx + COL_W'(1);
          if (clr_idx == COL_W'(MAX_COLS - 1)) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR) |-> !q_pop) else $error("item taken during clear");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |=> out_valid && $stable(result)) else $error("result lost");
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    stack_depth <= (COL_W+1)'(MAX_COLS)) else $error("stack overrun");
  a_last_waits: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_cmd.last_pixel) |-> !out_valid) else $error("result overwritten");
endmodule

// ===== hw/rtl/max_black_rectangle_area.sv =====
// top level of the maximal black rectangle block
// pixels enter on push/full in row-major order, one item per pixel; row_width
// sets columns per row (0 acts as 1, above MAX_COLS acts as MAX_COLS).
// an item with last_pixel high produces one best_area result on the output
// queue side: best_area is valid while empty is low and leaves on pop.
// the front tracks columns and flags row ends, a four-entry queue decouples it
// from the back, which updates the column height of each pixel in S_IDLE and
// S_HWR. at a row end the back adds a forward pass (read, compare) and a
// backward pass (read, compare, multiply, accumulate) per column, plus a pop
// step per stack pop and a closing step. one item at a time.
// after a last pixel the back clears the height memory entry by entry, and
// meanwhile no item is taken from the queue.
// reset (rst, synchronous) clears control state, sets row_width to 1024 and
// starts the same clearing pass; items queue up meanwhile.
// a stalled receiver holds the result; the back waits on the next last pixel
// until the previous result is popped, and full rises once the queue fills.
module max_black_rectangle_area #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [10:0] cfg_wdata,
  input  logic push,
  output logic full,
  input  logic pixel,
  input  logic last_pixel,
  output logic empty,
  input  logic pop,
  output logic [20:0] best_area
);
  import mbra_pkg::*;

  localparam int COL_W = $clog2(MAX_COLS);
  localparam int HGT_W = $clog2(MAX_ROWS + 1);

  logic [WIDTH_W-1:0] row_width;
  logic q_push, q_full, q_pop, q_empty;
  cmd_t f_cmd, b_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= WIDTH_W'(1024);
    end else if (cfg_we) begin
      row_width <= cfg_wdata;
    end
  end

  mbra_front #(.MAX_COLS(MAX_COLS), .COL_W(COL_W)) u_front (
    .clk, .rst, .row_width, .push, .pixel, .last_pixel,
    .q_full, .full, .q_push, .q_cmd(f_cmd)
  );

  mbra_queue #(.DEPTH_W(2)) u_queue (
    .clk, .rst, .push(q_push), .wdata(f_cmd), .full(q_full),
    .pop(q_pop), .rdata(b_cmd), .empty(q_empty)
  );

  mbra_back #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS), .COL_W(COL_W), .HGT_W(HGT_W)) u_back (
    .clk, .rst, .q_empty, .q_cmd(b_cmd), .q_pop, .empty, .pop, .best_area
  );
endmodule

// ===== sim/mbra_checker.sv =====
// checker for the maximal black rectangle block: predicts best_area per image and compares
`timescale 1ns / 1ps
module mbra_checker #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [10:0] cfg_wdata,
  input  logic push,
  input  logic full,
  input  logic pixel,
  input  logic last_pixel,
  input  logic empty,
  input  logic pop,
  input  logic [20:0] best_area,
  output int fail_count,
  output int pending_areas
);
  import mbra_pkg::*;

  logic [WIDTH_W-1:0] width_reg;
  int heights [MAX_COLS];
  int col_pos;
  longint image_best;
  logic [AREA_W-1:0] area_queue [$];

  assign pending_areas = area_queue.size();

  function automatic longint row_rectangle(int cols);
    int stk [MAX_COLS];
    int lb [MAX_COLS];
    int depth;
    int right;
    longint best;
    longint a;
    best = 0;
    depth = 0;
    for (int i = 0; i < cols; i++) begin
      while (depth > 0 && heights[stk[depth-1]] >= heights[i]) depth--;
      lb[i] = depth > 0 ? stk[depth-1] + 1 : 0;
      stk[depth++] = i;
    end
    depth = 0;
    for (int c = cols - 1; c >= 0; c--) begin
      while (depth > 0 && heights[stk[depth-1]] >= heights[c]) depth--;
      right = depth > 0 ? stk[depth-1] : cols;
      a = longint'(heights[c]) * (right - lb[c]);
      if (a > best) best = a;
      stk[depth++] = c;
    end
    return best;
  endfunction

  task automatic take_pixel(logic black, logic fin);
    int w;
    int p;
    longint a;
    w = width_reg;
    p = col_pos;
    if (w < 1) w = 1;
    if (w > MAX_COLS) w = MAX_COLS;
    if (p >= MAX_COLS) p = MAX_COLS - 1;
    if (black) begin
      if (heights[p] < MAX_ROWS) heights[p]++;
    end else begin
      heights[p] = 0;
    end
    if (p + 1 >= w || fin) begin
      a = row_rectangle(p + 1);
      if (a > AREA_LIMIT) a = AREA_LIMIT;
      if (a > image_best) image_best = a;
      col_pos = 0;
    end else begin
      col_pos = p + 1;
    end
    if (fin) begin
      area_queue.push_back(image_best[AREA_W-1:0]);
      foreach (heights[i]) heights[i] = 0;
      col_pos = 0;
      image_best = 0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg <= 11'd1024;
      foreach (heights[i]) heights[i] = 0;
      col_pos = 0;
      image_best = 0;
      area_queue.delete();
      fail_count <= 0;
    end else begin
      if (pop && !empty) begin
        if (area_queue.size() == 0) begin
          $error("best_area result with no image pending, actual %0d", best_area);
          fail_count <= fail_count + 1;
        end else begin
          if (best_area !== area_queue[0]) begin
            $error("best_area expected %0d actual %0d", area_queue[0], best_area);
            fail_count <= fail_count + 1;
          end
          void'(area_queue.pop_front());
        end
      end
      if (push && !full) take_pixel(pixel, last_pixel);
      if (cfg_we) width_reg <= cfg_wdata;
    end
  end
endmodule

// ===== sim/tb_max_black_rectangle_area.sv =====
// testbench top: drives images and width settings into the block and gives the verdict
`timescale 1ns / 1ps
module tb_max_black_rectangle_area;
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [10:0] cfg_wdata = '0;
  logic push = 1'b0;
  logic pixel = 1'b0;
  logic last_pixel = 1'b0;
  logic pop = 1'b0;
  logic full;
  logic empty;
  logic [20:0] best_area;
  int fail_count;
  int pending_areas;
  int pixels_sent;
  bit calm;
  longint cycles;

  localparam longint CYCLE_LIMIT = 64'd3000000;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  max_black_rectangle_area dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .push(push), .full(full), .pixel(pixel), .last_pixel(last_pixel),
    .empty(empty), .pop(pop), .best_area(best_area)
  );

  mbra_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .push(push), .full(full), .pixel(pixel), .last_pixel(last_pixel),
    .empty(empty), .pop(pop), .best_area(best_area),
    .fail_count(fail_count), .pending_areas(pending_areas)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver with random stall bursts
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        n = $urandom_range(1, 12);
        repeat (n - 1) @(posedge clk);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic send_pixel(logic black, logic fin);
    int n;
    if (!calm && $urandom_range(0, 6) == 0) begin
      push <= 1'b0;
      n = $urandom_range(1, 12);
      repeat (n) @(posedge clk);
    end
    push <= 1'b1;
    pixel <= black;
    last_pixel <= fin;
    @(posedge clk);
    while (full) @(posedge clk);
    pixels_sent++;
  endtask

  task automatic set_width(logic [10:0] w);
    push <= 1'b0;
    @(posedge clk);
    while (pending_areas != 0) @(posedge clk);
    repeat (1100) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // one image of rows x cols with black density percent, optional short last row
  task automatic send_image(int rows, int cols, int density, int tail);
    for (int r = 0; r < rows; r++)
      for (int c = 0; c < cols; c++)
        send_pixel($urandom_range(0, 99) < density, (tail == 0) && r == rows-1 && c == cols-1);
    for (int c = 0; c < tail; c++)
      send_pixel($urandom_range(0, 99) < density, c == tail - 1);
  endtask

  initial begin
    int w;
    pixels_sent = 0;
    calm = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: reset width, lone pixels, all black, all white
    send_pixel(1'b1, 1'b1);
    send_pixel(1'b0, 1'b1);
    set_width(11'd0);
    send_image(3, 1, 100, 0);
    set_width(11'd2047);
    send_image(1, 4, 100, 0);
    set_width(11'd3);
    send_image(2, 3, 100, 1);
    send_image(2, 3, 0, 0);
    // width change mid-row ends the row
    send_pixel(1'b1, 1'b0);
    send_pixel(1'b1, 1'b0);
    set_width(11'd2);
    send_pixel(1'b1, 1'b1);
    // wider rows
    set_width(11'd64);
    send_image(2, 64, 90, 0);
    while (pixels_sent < 850) begin
      w = $urandom_range(0, 9) == 0 ? $urandom_range(1, 40) : $urandom_range(1, 8);
      set_width(w[10:0]);
      repeat ($urandom_range(1, 3))
        send_image($urandom_range(1, 6), w, $urandom_range(0, 100),
                   $urandom_range(0, 2) == 0 ? $urandom_range(1, w) - 1 : 0);
      if (pixels_sent > 700) calm = 1'b1;
    end
    push <= 1'b0;
    @(posedge clk);
    while (pending_areas != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/mbra_pkg.sv
hw/rtl/mbra_front.sv
hw/rtl/mbra_queue.sv
hw/rtl/mbra_back.sv
hw/rtl/max_black_rectangle_area.sv
sim/mbra_checker.sv
sim/tb_max_black_rectangle_area.sv
